// ===== rtl/core/r2y_pkg.sv =====
// r2y_pkg: shared constants, codes and stage types of the RGB to YUV 4:2:0 converter.
// No dependencies; imported by every module of the block but r2y_line_ram.
package r2y_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int HT_W       = ROW_W + 1;

  localparam int CFG_WID_W  = 12;
  localparam int CFG_HT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_HT_W-1:0]  HEIGHT_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic KIND_LUMA   = 1'b0;
  localparam logic KIND_CHROMA = 1'b1;

  // Pair sums of one horizontal pixel pair, as kept in the line store
  typedef struct packed {
    logic [8:0] b;
    logic [8:0] g;
    logic [8:0] r;
  } psum_t;

  localparam int PSUM_W = $bits(psum_t);

  typedef struct packed {
    logic       chroma;
    logic       eof;
    logic [7:0] luma;
    psum_t      pair;
  } pix_t;

  typedef struct packed {
    logic       chroma;
    logic       eof;
    logic [7:0] luma;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } avg_t;

  typedef struct packed {
    logic       chroma;
    logic       eof;
    logic [7:0] luma;
    logic [7:0] u;
    logic [7:0] v;
  } res_t;

endpackage

// ===== rtl/core/r2y_line_ram.sv =====
// r2y_line_ram: single-port synchronous RAM, one access a cycle, registered read data.
// Generic; no package dependency.
module r2y_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 27
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/r2y_front.sv =====
// r2y_front: configuration registers, raster counters, pixel pairing, luma and line store access.
// Depends on r2y_pkg; drives the line RAM and the first pipeline stage.
module r2y_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [r2y_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [r2y_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  output logic                            in_ready,
  input  logic                            s2_free,
  output logic                            s1_v,
  output r2y_pkg::pix_t                   s1,
  output logic                            ram_we,
  output logic                            ram_re,
  output logic [r2y_pkg::LINE_AW-1:0]     ram_addr,
  output r2y_pkg::psum_t                  ram_wdata
);
  import r2y_pkg::*;

  logic [CFG_WID_W-1:0] width_r;
  logic [CFG_HT_W-1:0]  height_r;
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic [7:0]           held_r_r, held_g_r, held_b_r;
  logic                 s1_v_r;
  pix_t                 s1_r;

  logic [EW_W-1:0]  eff_w, ew, col_x, col_p1;
  logic [HT_W-1:0]  eff_h, eh, row_x, row_p1;
  logic             accept, in_area, odd_col, odd_row, s1_free;
  logic [15:0]      y_sum;
  logic [7:0]       luma;
  psum_t            pair;

  always_comb begin
    if (width_r < CFG_WID_W'(2)) begin
      eff_w = EW_W'(2);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(width_r);
    end
    if (height_r < CFG_HT_W'(2)) begin
      eff_h = HT_W'(2);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      eff_h = HT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HT_W'(height_r);
    end
  end

  assign ew      = {eff_w[EW_W-1:1], 1'b0};
  assign eh      = {eff_h[HT_W-1:1], 1'b0};
  assign col_x   = EW_W'(col_r);
  assign row_x   = HT_W'(row_r);
  assign col_p1  = col_x + EW_W'(1);
  assign row_p1  = row_x + HT_W'(1);
  assign in_area = (col_x < ew) && (row_x < eh);
  assign odd_col = col_r[0];
  assign odd_row = row_r[0];

  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign accept   = in_valid && s1_free;

  assign y_sum = 16'd66 * {8'd0, in_red} + 16'd129 * {8'd0, in_green}
               + 16'd25 * {8'd0, in_blue} + 16'd128;
  assign luma  = y_sum[15:8] + 8'd16;

  assign pair.r = {1'b0, in_red}   + {1'b0, held_r_r};
  assign pair.g = {1'b0, in_green} + {1'b0, held_g_r};
  assign pair.b = {1'b0, in_blue}  + {1'b0, held_b_r};

  // even row stores its pair sums; odd row fetches them for the block
  assign ram_we    = accept && in_area && odd_col && !odd_row;
  assign ram_re    = accept && in_area && odd_col && odd_row;
  assign ram_addr  = LINE_AW'(col_r >> 1);
  assign ram_wdata = pair;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      held_r_r <= '0;
      held_g_r <= '0;
      held_b_r <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_r  <= cfg_wdata[CFG_WID_W-1:0];
          REG_FRAME_HEIGHT: height_r <= cfg_wdata[CFG_HT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (col_p1 >= eff_w) begin
          col_r <= '0;
          if (row_p1 >= eff_h) begin
            row_r <= '0;
          end else begin
            row_r <= row_p1[ROW_W-1:0];
          end
        end else begin
          col_r <= col_p1[COL_W-1:0];
        end
        if (in_area && !odd_col) begin
          held_r_r <= in_red;
          held_g_r <= in_green;
          held_b_r <= in_blue;
        end
      end
      if (s1_free) begin
        s1_v_r <= accept && in_area;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_r.chroma <= odd_col && odd_row;
      s1_r.eof    <= (row_x == eh - HT_W'(1)) && (col_x == ew - EW_W'(1));
      s1_r.luma   <= luma;
      s1_r.pair   <= pair;
    end
  end

  assign s1_v = s1_v_r;
  assign s1   = s1_r;

endmodule

// ===== rtl/core/r2y_chroma.sv =====
// r2y_chroma: block averaging against the line store data and the U/V products.
// Depends on r2y_pkg; fed by r2y_front and the line RAM, feeds r2y_emit.
module r2y_chroma (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_v,
  input  r2y_pkg::pix_t  s1,
  input  r2y_pkg::psum_t rd_data,
  input  logic           s3_free,
  output logic           s2_free,
  output logic           s3_v,
  output r2y_pkg::res_t  s3
);
  import r2y_pkg::*;

  logic  s2_v_r, s3_v_r;
  avg_t  s2_r;
  res_t  s3_r;

  logic [9:0]  sum_r, sum_g, sum_b;
  logic [15:0] u_acc, v_acc;

  // line store data stays put until the next read, which waits for s1 to move
  assign sum_r = {1'b0, s1.pair.r} + {1'b0, rd_data.r};
  assign sum_g = {1'b0, s1.pair.g} + {1'b0, rd_data.g};
  assign sum_b = {1'b0, s1.pair.b} + {1'b0, rd_data.b};

  // low 16 bits wrap exactly, so bits 15:8 are the floored shift
  assign u_acc = 16'd112 * {8'd0, s2_r.b} - 16'd38 * {8'd0, s2_r.r}
               - 16'd74 * {8'd0, s2_r.g} + 16'd128;
  assign v_acc = 16'd112 * {8'd0, s2_r.r} - 16'd94 * {8'd0, s2_r.g}
               - 16'd18 * {8'd0, s2_r.b} + 16'd128;

  assign s2_free = !s2_v_r || s3_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_r <= s1_v;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_r.chroma <= s1.chroma;
      s2_r.eof    <= s1.eof;
      s2_r.luma   <= s1.luma;
      s2_r.r      <= s1.chroma ? sum_r[9:2] : 8'd0;
      s2_r.g      <= s1.chroma ? sum_g[9:2] : 8'd0;
      s2_r.b      <= s1.chroma ? sum_b[9:2] : 8'd0;
    end
    if (s3_free) begin
      s3_r.chroma <= s2_r.chroma;
      s3_r.eof    <= s2_r.eof;
      s3_r.luma   <= s2_r.luma;
      s3_r.u      <= u_acc[15:8] + 8'd128;
      s3_r.v      <= v_acc[15:8] + 8'd128;
    end
  end

  assign s3_v = s3_v_r;
  assign s3   = s3_r;

endmodule

// ===== rtl/core/r2y_emit.sv =====
// r2y_emit: output register; splits a block item into its luma and chroma results.
// Depends on r2y_pkg; fed by r2y_chroma, drives the result channel.
module r2y_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s3_v,
  input  r2y_pkg::res_t s3,
  output logic          s3_free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_result_kind,
  output logic [7:0]    out_luma,
  output logic [7:0]    out_blue_diff,
  output logic [7:0]    out_red_diff,
  output logic          out_last_of_run,
  output logic          out_end_of_frame
);
  import r2y_pkg::*;

  logic       out_valid_r, phase_r;
  logic       kind_r, last_r, eof_r;
  logic [7:0] luma_r, u_r, v_r;
  logic       load, done;

  assign load    = s3_v && (!out_valid_r || out_ready);
  assign done    = load && (!s3.chroma || phase_r);
  assign s3_free = !s3_v || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (done) begin
        phase_r <= 1'b0;
      end else if (load) begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (phase_r) begin
        kind_r <= KIND_CHROMA;
        luma_r <= 8'd0;
        u_r    <= s3.u;
        v_r    <= s3.v;
        last_r <= 1'b1;
        eof_r  <= s3.eof;
      end else begin
        kind_r <= KIND_LUMA;
        luma_r <= s3.luma;
        u_r    <= 8'd0;
        v_r    <= 8'd0;
        last_r <= !s3.chroma;
        eof_r  <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_luma         = luma_r;
  assign out_blue_diff    = u_r;
  assign out_red_diff     = v_r;
  assign out_last_of_run  = last_r;
  assign out_end_of_frame = eof_r;

endmodule

// ===== rtl/core/rgb_to_yuv420_converter.sv =====
// rgb_to_yuv420_converter: BT.601 integer RGB to YUV 4:2:0, pixels in raster order.
// A pixel's luma result passes registers s1, s2, s3 and the output register; the block's chroma
// result follows from the same s3 item once the luma one is taken. One pixel per cycle on even
// rows while out_ready is high; on odd rows the single port gives three results per pixel pair.
// Reset (synchronous, rst_n low): counters cleared, width 640, height 480; line store not cleared.
// Depends on r2y_pkg, r2y_front, r2y_line_ram, r2y_chroma, r2y_emit.
module rgb_to_yuv420_converter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [r2y_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [r2y_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_result_kind,
  output logic [7:0]                      out_luma,
  output logic [7:0]                      out_blue_diff,
  output logic [7:0]                      out_red_diff,
  output logic                            out_last_of_run,
  output logic                            out_end_of_frame
);
  import r2y_pkg::*;

  logic               s1_v, s2_free, s3_v, s3_free;
  pix_t               s1;
  res_t               s3;
  logic               ram_we, ram_re;
  logic [LINE_AW-1:0] ram_addr;
  psum_t              ram_wdata, ram_rdata;

  r2y_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_ready  (in_ready),
    .s2_free   (s2_free),
    .s1_v      (s1_v),
    .s1        (s1),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata)
  );

  // a write and the read of the same entry are always at least a row apart
  r2y_line_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (PSUM_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  r2y_chroma u_chroma (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_v    (s1_v),
    .s1      (s1),
    .rd_data (ram_rdata),
    .s3_free (s3_free),
    .s2_free (s2_free),
    .s3_v    (s3_v),
    .s3      (s3)
  );

  r2y_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .s3_v             (s3_v),
    .s3               (s3),
    .s3_free          (s3_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_luma         (out_luma),
    .out_blue_diff    (out_blue_diff),
    .out_red_diff     (out_red_diff),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// ===== rtl/core/r2y_checker.sv =====
// r2y_checker: port-level assertions on the result channel of the converter, and its bind.
// Depends on r2y_pkg; attached to rgb_to_yuv420_converter.
module r2y_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_result_kind,
  input logic [7:0] out_luma,
  input logic [7:0] out_blue_diff,
  input logic [7:0] out_red_diff,
  input logic       out_last_of_run,
  input logic       out_end_of_frame
);
  import r2y_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) && $stable(out_luma)
      && $stable(out_blue_diff) && $stable(out_red_diff) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // a luma item that is not last of its pixel is followed at once by its chroma item
  a_chroma_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_result_kind == KIND_LUMA) && !out_last_of_run
      |=> out_valid && (out_result_kind == KIND_CHROMA))
    else $error("chroma item missing after block luma");

  a_chroma_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_CHROMA) |-> out_last_of_run && (out_luma == 8'd0))
    else $error("malformed chroma item");

  a_eof_on_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> (out_result_kind == KIND_CHROMA))
    else $error("end of frame on a luma item");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_LUMA) |-> (out_luma >= 8'd16) && (out_luma <= 8'd235)
      && (out_blue_diff == 8'd0) && (out_red_diff == 8'd0))
    else $error("luma item out of range");

endmodule

bind rgb_to_yuv420_converter r2y_checker u_r2y_checker (.*);

// ===== tb/sv/rgb_to_yuv420_converter_test.sv =====
// Self-checking bench for rgb_to_yuv420_converter: random-timed pixel stream, frame resizes
// between runs and mid-frame, results checked in order against a built-in BT.601 predictor.
// Depends on r2y_pkg and the rgb_to_yuv420_converter RTL.
module rgb_to_yuv420_converter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import r2y_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       last_of_run;
    logic       end_of_frame;
  } yuv_result_t;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 16;

  // Blue and cyan blocks; yellow block with trailing column and row; red and checker blocks
  localparam logic [23:0] DIRECTED_PX [25] = '{
    24'h0000FF, 24'h0000FF, 24'h00FFFF, 24'h00FFFF,
    24'h0000FF, 24'h0000FF, 24'h00FFFF, 24'h00FFFF,
    24'hFFFF00, 24'hFFFF00, 24'hFFFFFF,
    24'hFFFF00, 24'hFFFF00, 24'h000000,
    24'hFFFFFF, 24'h000000, 24'h123456,
    24'hFF0000, 24'hFF0000, 24'hFFFFFF, 24'h000000,
    24'hFF0000, 24'hFF0000, 24'h000000, 24'hFFFFFF
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_red    = 8'd0;
  logic [7:0]            in_green  = 8'd0;
  logic [7:0]            in_blue   = 8'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_result_kind;
  logic [7:0]            out_luma;
  logic [7:0]            out_blue_diff;
  logic [7:0]            out_red_diff;
  logic                  out_last_of_run;
  logic                  out_end_of_frame;

  rgb_to_yuv420_converter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_luma         (out_luma),
    .out_blue_diff    (out_blue_diff),
    .out_red_diff     (out_red_diff),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  pixel_t      pending_pixels[$];
  yuv_result_t expected_yuv[$];

  int error_count     = 0;
  int pixels_accepted = 0;
  int results_checked = 0;
  int chroma_checked  = 0;
  int reg_writes      = 0;

  // Predictor state
  logic [CFG_WID_W-1:0] frame_width  = WIDTH_RESET;
  logic [CFG_HT_W-1:0]  frame_height = HEIGHT_RESET;
  int                   pos_col      = 0;
  int                   pos_row      = 0;
  pixel_t               held_px      = '0;
  psum_t                pair_line [LINE_DEPTH];

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Work out the results one accepted pixel causes and advance the raster position
  task automatic convert_pixel(input pixel_t px);
    int w, h, ew, eh, idx, y, sr, sg, sb, ar, ag, ab, u, v;
    psum_t above;
    yuv_result_t res;
    w = int'(frame_width);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = int'(frame_height);
    if (h < 2) h = 2;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    ew = w & ~1;
    eh = h & ~1;
    if (pos_col < ew && pos_row < eh) begin
      y = ((66 * px.red + 129 * px.green + 25 * px.blue + 128) >> 8) + 16;
      res = '{kind: KIND_LUMA, luma: y[7:0], blue_diff: 8'd0, red_diff: 8'd0,
              last_of_run: 1'b1, end_of_frame: 1'b0};
      idx = pos_col >> 1;
      if (pos_col % 2 == 0) begin
        held_px = px;
        expected_yuv.push_back(res);
      end else begin
        sr = int'(px.red) + int'(held_px.red);
        sg = int'(px.green) + int'(held_px.green);
        sb = int'(px.blue) + int'(held_px.blue);
        if (pos_row % 2 == 0) begin
          pair_line[idx] = '{b: sb[8:0], g: sg[8:0], r: sr[8:0]};
          expected_yuv.push_back(res);
        end else begin
          above = pair_line[idx];
          ar = (sr + above.r) >> 2;
          ag = (sg + above.g) >> 2;
          ab = (sb + above.b) >> 2;
          u = ((-38 * ar - 74 * ag + 112 * ab + 128) >>> 8) + 128;
          v = ((112 * ar - 94 * ag - 18 * ab + 128) >>> 8) + 128;
          res.last_of_run = 1'b0;
          expected_yuv.push_back(res);
          res = '{kind: KIND_CHROMA, luma: 8'd0, blue_diff: u[7:0], red_diff: v[7:0],
                  last_of_run: 1'b1,
                  end_of_frame: (pos_row == eh - 1 && pos_col == ew - 1)};
          expected_yuv.push_back(res);
        end
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got)
      flag_error($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                           results_checked, name, want, got));
  endtask

  // Sender: one item per handshake, random gaps outside a calm window
  int     send_cycle = 0;
  pixel_t next_px;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      send_cycle++;
      if (in_valid && in_ready) begin
        convert_pixel('{red: in_red, green: in_green, blue: in_blue});
        pixels_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() != 0 &&
            ((send_cycle >= 300 && send_cycle < 1000) || $urandom_range(0, 99) >= 30)) begin
          next_px = pending_pixels.pop_front();
          in_valid <= 1'b1;
          in_red   <= next_px.red;
          in_green <= next_px.green;
          in_blue  <= next_px.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each result with the oldest prediction, stall at random
  int          recv_cycle = 0;
  int          hold_left  = 0;
  int          next_hold  = 350;
  yuv_result_t got_res;
  yuv_result_t want_res;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      recv_cycle++;
      if (out_valid && out_ready) begin
        got_res = '{out_result_kind, out_luma, out_blue_diff, out_red_diff,
                    out_last_of_run, out_end_of_frame};
        if (expected_yuv.size() == 0) begin
          flag_error($sformatf("unexpected result 0x%0h", got_res));
        end else begin
          want_res = expected_yuv.pop_front();
          check_field("result_kind", int'(want_res.kind), int'(got_res.kind));
          check_field("luma", int'(want_res.luma), int'(got_res.luma));
          check_field("blue_diff", int'(want_res.blue_diff), int'(got_res.blue_diff));
          check_field("red_diff", int'(want_res.red_diff), int'(got_res.red_diff));
          check_field("last_of_run", int'(want_res.last_of_run), int'(got_res.last_of_run));
          check_field("end_of_frame", int'(want_res.end_of_frame),
                      int'(got_res.end_of_frame));
          if (want_res.kind == KIND_CHROMA) chroma_checked++;
        end
        results_checked++;
      end
      // Back up the block now and then while the sender keeps offering
      if (hold_left != 0) begin
        hold_left--;
      end else if (results_checked == next_hold) begin
        hold_left = LONG_HOLD;
        next_hold = next_hold + 1200;
      end
      out_ready <= (hold_left == 0) &&
                   ((recv_cycle >= 1300 && recv_cycle < 1800) || $urandom_range(0, 99) >= 30);
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_width = data[CFG_WID_W-1:0];
    else frame_height = data[CFG_HT_W-1:0];
    reg_writes++;
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // Hold until every item is through, then let trailing pixels with no result clear
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_yuv.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int mode;
    mode    = $urandom_range(0, 9);
    p.red   = 8'($urandom_range(0, 255));
    p.green = 8'($urandom_range(0, 255));
    p.blue  = 8'($urandom_range(0, 255));
    if (mode == 0) begin
      p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else if (mode == 1) begin
      p.green = p.red;
      p.blue  = p.red;
    end
    return p;
  endfunction

  task automatic send_random(input int count);
    @(negedge clk);
    repeat (count) pending_pixels.push_back(random_pixel());
    wait_idle();
  endtask

  task automatic send_directed(input int first, input int count);
    @(negedge clk);
    for (int i = first; i < first + count; i++) pending_pixels.push_back(DIRECTED_PX[i]);
    wait_idle();
  endtask

  initial begin
    int w, h;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_frame(13'd4, 13'd2);
    send_directed(0, 8);
    set_frame(13'd3, 13'd3);
    send_directed(8, 9);
    set_frame(13'd4, 13'd2);
    send_directed(17, 8);

    // Below-minimum sizes saturate to 2x2
    set_frame(13'd0, 13'd1);
    send_random(24);
    set_frame(13'd13, 13'd7);
    send_random(91);
    // Upper width bits are outside the register
    set_frame(13'h1010, 13'd8);
    send_random(128);

    // Saturated width, then narrow it on the even row past the new edge
    set_frame(13'h0FFF, 13'd2);
    send_random(100);
    write_reg(REG_FRAME_WIDTH, 13'd60);
    send_random(61);

    // Narrow the width while on the odd row past the new edge
    set_frame(13'd40, 13'd2);
    send_random(40 + 30);
    write_reg(REG_FRAME_WIDTH, 13'd20);
    send_random(1);

    // Tallest frame, then shrink the height below the current row
    set_frame(13'd2, 13'h1FFF);
    send_random(50);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    send_random(26);

    // Narrow and widen on an even row mid-frame
    set_frame(13'd10, 13'd4);
    send_random(28);
    write_reg(REG_FRAME_WIDTH, 13'd4);
    send_random(5);
    write_reg(REG_FRAME_WIDTH, 13'd6);
    send_random(3);
    write_reg(REG_FRAME_WIDTH, 13'd10);
    send_random(37);

    repeat (2) begin
      w = $urandom_range(2, 24);
      h = $urandom_range(2, 10);
      set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
      send_random(w * h * $urandom_range(1, 2));
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Streamed %0d pixels over %0d register writes: small to saturated frames, odd edges,",
             pixels_accepted, reg_writes);
    $display("saturated sizes and mid-frame resizes; %0d results checked, %0d chroma, %0d errors",
             results_checked, chroma_checked, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/r2y_pkg.sv
rtl/core/r2y_line_ram.sv
rtl/core/r2y_front.sv
rtl/core/r2y_chroma.sv
rtl/core/r2y_emit.sv
rtl/core/rgb_to_yuv420_converter.sv
rtl/core/r2y_checker.sv
tb/sv/rgb_to_yuv420_converter_test.sv
